>>> rtl/core/srtf_pkg.sv
// shared types and constants for the srtf scheduler
package srtf_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    localparam logic REG_PROCESS_COUNT = 1'b0;
    localparam logic REG_RUN_LENGTH    = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the input item
        logic do_load;     // write the loaded slot
        logic scan_clear;  // reset scan index; also found flag and arrival mask unless run_best is set
        logic scan_step;   // examine one slot for the minimum
        logic upd_step;    // update one slot's wait
        logic run_best;    // decrement the chosen slot
        logic advance;     // bump current time
        logic emit;        // present the result
    } srtf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;   // scan index at last active slot
        logic no_active;   // zero slots in use
        logic past_end;    // current time reached run length
        logic found;       // some slot is ready
    } srtf_sts_t;

endpackage

>>> rtl/core/srtf_process_scheduler.sv
// top level of the shortest-remaining-time-first scheduler
//
// channel  | handshake                 | payload
// ---------+---------------------------+----------------------------------------
// command  | start & !busy             | opcode, slot, arrival_time, burst_time
// result   | done (one cycle strobe)   | tick_time .. has_finished
// config   | cfg_we                    | cfg_index, cfg_data
//
// a load or report goes from idle through dispatch and output to done
// a tick examines one slot per cycle in the minimum scan, then, if a slot was chosen,
//   one slot per cycle in the wait update pass
// a tick past run length goes straight from dispatch to output
// reset clears all slot records except the arrival memory; no clearing pass
// the result strobe cannot be held off, so busy alone paces the sender
module srtf_process_scheduler #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [3:0]  slot,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_time,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [15:0] tick_time,
    output logic [15:0] arrived_mask,
    output logic        idle,
    output logic        new_selection,
    output logic [3:0]  chosen_slot,
    output logic [15:0] burst_left,
    output logic        finished,
    output logic        past_end,
    output logic [15:0] wait_total,
    output logic [15:0] turnaround,
    output logic        has_finished
);
    import srtf_pkg::*;

    srtf_cmd_t cmd;
    srtf_sts_t sts;
    logic      go;

    // only a start that the controller accepts may enter
    assign go = start && !busy;

    srtf_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (go),
        .opcode (opcode),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    srtf_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .slot          (slot),
        .arrival_time  (arrival_time),
        .burst_time    (burst_time),
        .done          (done),
        .tick_time     (tick_time),
        .arrived_mask  (arrived_mask),
        .idle          (idle),
        .new_selection (new_selection),
        .chosen_slot   (chosen_slot),
        .burst_left    (burst_left),
        .finished      (finished),
        .past_end      (past_end),
        .wait_total    (wait_total),
        .turnaround    (turnaround),
        .has_finished  (has_finished)
    );
endmodule

>>> rtl/core/srtf_ctrl.sv
// sequencing state machine for the srtf scheduler
module srtf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          opcode,
    input  srtf_pkg::srtf_sts_t sts,
    output logic                busy,
    output srtf_pkg::srtf_cmd_t cmd
);
    import srtf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            if (start && state_reg == S_IDLE)
                op_reg <= opcode;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.scan_clear = 1'b1;
                if (op_reg == OP_TICK)
                begin
                    if (sts.past_end)
                        state_next = S_OUT;
                    else if (sts.no_active)
                        state_next = S_RUN;
                    else
                        state_next = S_SCAN;
                end
                else
                begin
                    cmd.do_load = (op_reg == OP_LOAD);
                    state_next  = S_OUT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.run_best   = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next = (sts.found && !sts.no_active) ? S_UPD : S_OUT;
            end
            S_UPD:
            begin
                cmd.upd_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.emit    = 1'b1;
                // time moves only after the wait pass has used it
                cmd.advance = (op_reg == OP_TICK) && !sts.past_end;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

>>> rtl/core/srtf_dp.sv
// slot stores, minimum scan and result formation for the srtf scheduler
module srtf_dp #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  srtf_pkg::srtf_cmd_t cmd,
    output srtf_pkg::srtf_sts_t sts,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [1:0]          opcode,
    input  logic [3:0]          slot,
    input  logic [15:0]         arrival_time,
    input  logic [15:0]         burst_time,
    output logic                done,
    output logic [15:0]         tick_time,
    output logic [15:0]         arrived_mask,
    output logic                idle,
    output logic                new_selection,
    output logic [3:0]          chosen_slot,
    output logic [15:0]         burst_left,
    output logic                finished,
    output logic                past_end,
    output logic [15:0]         wait_total,
    output logic [15:0]         turnaround,
    output logic                has_finished
);
    import srtf_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    logic [TIME_BITS-1:0] arr_mem [SLOTS];
    logic [TIME_BITS-1:0] rem_reg [SLOTS];
    logic [TIME_BITS-1:0] wait_reg [SLOTS];
    logic [TIME_BITS-1:0] fin_reg [SLOTS];
    logic [SLOTS-1:0]     done_reg;

    logic [4:0]           pcount_reg;
    logic [15:0]          runlen_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [IW-1:0]        last_reg;
    logic                 last_valid_reg;

    logic [1:0]           op_reg;
    logic [3:0]           slot_reg;
    logic [TIME_BITS-1:0] a_in_reg, b_in_reg;

    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        best_reg;
    logic [TIME_BITS-1:0] best_rem_reg;
    logic                 found_reg;
    logic [15:0]          mask_reg;

    logic [CW-1:0]        n_act;
    logic                 slot_ok;
    logic [IW-1:0]        slot_i;
    logic                 ready_i;
    logic                 rpt_ok;
    logic                 rpt_done;

    assign n_act = ({{(CW > 5 ? CW-5 : 0){1'b0}}, pcount_reg} > CW'(SLOTS))
                   ? CW'(SLOTS) : CW'(pcount_reg);
    assign slot_ok = ({28'd0, slot_reg} < SLOTS);
    assign slot_i  = IW'(slot_reg);
    assign ready_i = (rem_reg[idx_reg] != '0) && (arr_mem[idx_reg] <= time_reg);
    assign rpt_ok   = (op_reg == OP_REPORT) && slot_ok;
    assign rpt_done = rpt_ok && done_reg[slot_i];

    assign sts.scan_last = ({1'b0, idx_reg} + (CW+1)'(1) >= (CW+1)'(n_act));
    assign sts.no_active = (n_act == '0);
    assign sts.past_end  = ({{(TIME_BITS > 16 ? 0 : 16-TIME_BITS){1'b0}}, time_reg}
                            >= {{(TIME_BITS > 16 ? TIME_BITS-16 : 0){1'b0}}, runlen_reg});
    assign sts.found     = found_reg;

    // arrival memory
    always_ff @(posedge clk)
    begin
        if (cmd.do_load && slot_ok)
            arr_mem[slot_i] <= a_in_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                rem_reg[i]  <= '0;
                wait_reg[i] <= '0;
                fin_reg[i]  <= '0;
            end
            done_reg       <= '0;
            pcount_reg     <= 5'd1;
            runlen_reg     <= '0;
            time_reg       <= '0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            done           <= 1'b0;
            idx_reg        <= '0;
            best_reg       <= '0;
            best_rem_reg   <= '0;
            found_reg      <= 1'b0;
            mask_reg       <= '0;
            op_reg         <= '0;
            slot_reg       <= '0;
            a_in_reg       <= '0;
            b_in_reg       <= '0;
            tick_time      <= '0;
            arrived_mask   <= '0;
            idle           <= 1'b0;
            new_selection  <= 1'b0;
            chosen_slot    <= '0;
            burst_left     <= '0;
            finished       <= 1'b0;
            past_end       <= 1'b0;
            wait_total     <= '0;
            turnaround     <= '0;
            has_finished   <= 1'b0;
        end
        else
        begin
            done <= cmd.emit;
            if (cfg_we)
            begin
                if (cfg_index == REG_PROCESS_COUNT)
                    pcount_reg <= cfg_data[4:0];
                else
                    runlen_reg <= cfg_data;
            end
            if (cmd.capture)
            begin
                op_reg   <= opcode;
                slot_reg <= slot;
                a_in_reg <= TIME_BITS'(arrival_time);
                b_in_reg <= TIME_BITS'(burst_time);
            end
            if (cmd.do_load && slot_ok)
            begin
                rem_reg[slot_i]  <= b_in_reg;
                wait_reg[slot_i] <= '0;
                fin_reg[slot_i]  <= '0;
                done_reg[slot_i] <= 1'b0;
            end
            if (cmd.scan_clear)
            begin
                idx_reg <= '0;
                if (!cmd.run_best)
                begin
                    found_reg <= 1'b0;
                    mask_reg  <= '0;
                end
            end
            // one slot per cycle minimum search
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + IW'(1);
                if ({{(32-IW){1'b0}}, idx_reg} < 16 && arr_mem[idx_reg] == time_reg)
                    mask_reg[4'(idx_reg)] <= 1'b1;
                if (ready_i && (!found_reg || rem_reg[idx_reg] < best_rem_reg))
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= idx_reg;
                    best_rem_reg <= rem_reg[idx_reg];
                end
            end
            if (cmd.run_best && found_reg && !sts.no_active)
            begin
                rem_reg[best_reg] <= best_rem_reg - TIME_BITS'(1);
                if (best_rem_reg == TIME_BITS'(1))
                begin
                    fin_reg[best_reg]  <= time_reg + TIME_BITS'(1);
                    done_reg[best_reg] <= 1'b1;
                end
                last_reg       <= best_reg;
                last_valid_reg <= 1'b1;
            end
            if (cmd.advance)
                time_reg <= time_reg + TIME_BITS'(1);
            // wait pass, best slot already decremented
            if (cmd.upd_step)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (idx_reg != best_reg && ready_i && wait_reg[idx_reg] != TMAX)
                    wait_reg[idx_reg] <= wait_reg[idx_reg] + TIME_BITS'(1);
            end
            // the tick result is built during run (a past-end tick at dispatch), others at emit
            if (cmd.run_best)
            begin
                tick_time     <= 16'(time_reg);
                arrived_mask  <= sts.no_active ? 16'd0 : mask_reg;
                idle          <= !found_reg || sts.no_active;
                new_selection <= found_reg && !sts.no_active
                                 && (!last_valid_reg || last_reg != best_reg);
                chosen_slot   <= (found_reg && !sts.no_active) ? 4'(best_reg) : 4'd0;
                burst_left    <= (found_reg && !sts.no_active) ? 16'(best_rem_reg) : 16'd0;
                finished      <= found_reg && !sts.no_active && best_rem_reg == TIME_BITS'(1);
                past_end      <= 1'b0;
                wait_total    <= '0;
                turnaround    <= '0;
                has_finished  <= 1'b0;
            end
            if (cmd.emit && op_reg != OP_TICK)
            begin
                tick_time     <= '0;
                arrived_mask  <= '0;
                idle          <= 1'b0;
                new_selection <= 1'b0;
                burst_left    <= '0;
                finished      <= 1'b0;
                past_end      <= 1'b0;
                chosen_slot   <= (op_reg == OP_LOAD || op_reg == OP_REPORT) ? slot_reg : 4'd0;
                wait_total    <= rpt_ok ? 16'(wait_reg[slot_i]) : 16'd0;
                turnaround    <= rpt_done ? 16'(fin_reg[slot_i] - arr_mem[slot_i]) : 16'd0;
                has_finished  <= rpt_done;
            end
            if (cmd.scan_clear && !cmd.run_best && op_reg == OP_TICK && sts.past_end)
            begin
                tick_time     <= 16'(time_reg);
                arrived_mask  <= '0;
                idle          <= 1'b0;
                new_selection <= 1'b0;
                chosen_slot   <= '0;
                burst_left    <= '0;
                finished      <= 1'b0;
                past_end      <= 1'b1;
                wait_total    <= '0;
                turnaround    <= '0;
                has_finished  <= 1'b0;
            end
        end
    end
endmodule

>>> rtl/core/srtf_checker.sv
// port level checks for the srtf scheduler, bound to the top level
module srtf_port_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       idle,
    input logic       finished,
    input logic       past_end,
    input logic       new_selection,
    input logic       has_finished,
    input logic [15:0] turnaround
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");
    a_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && idle |-> !finished && !new_selection && !past_end)
        else $error("idle tick with run flags");
    a_ta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !has_finished |-> turnaround == 16'd0)
        else $error("turnaround without finish");
endmodule

bind srtf_process_scheduler srtf_port_checker u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .idle          (idle),
    .finished      (finished),
    .past_end      (past_end),
    .new_selection (new_selection),
    .has_finished  (has_finished),
    .turnaround    (turnaround)
);

>>> dv/srtf_checker.sv
// scoreboard for the srtf scheduler: predicts each result and compares it
module srtf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  logic [3:0]  slot,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_time,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        done,
    input  logic [15:0] tick_time,
    input  logic [15:0] arrived_mask,
    input  logic        idle,
    input  logic        new_selection,
    input  logic [3:0]  chosen_slot,
    input  logic [15:0] burst_left,
    input  logic        finished,
    input  logic        past_end,
    input  logic [15:0] wait_total,
    input  logic [15:0] turnaround,
    input  logic        has_finished,
    output int          failures,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import srtf_pkg::*;

    typedef struct packed {
        logic [15:0] tick_time;
        logic [15:0] arrived_mask;
        logic        idle;
        logic        new_selection;
        logic [3:0]  chosen_slot;
        logic [15:0] burst_left;
        logic        finished;
        logic        past_end;
        logic [15:0] wait_total;
        logic [15:0] turnaround;
        logic        has_finished;
    } sched_result_t;

    logic [15:0] arrival_mem [16];
    logic [15:0] remain_mem [16];
    logic [15:0] wait_mem [16];
    logic [15:0] finish_mem [16];
    logic [15:0] done_bits;
    logic [15:0] now;
    logic [3:0]  prev_pick;
    logic        prev_pick_ok;
    logic [4:0]  proc_count;
    logic [15:0] run_len;

    sched_result_t result_q [$];

    assign pending = result_q.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        failures++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic sched_result_t schedule_step(input logic [1:0] op,
                                                    input logic [3:0] sl,
                                                    input logic [15:0] arr,
                                                    input logic [15:0] bur);
        sched_result_t r;
        int          n;
        bit          found;
        int          best;
        logic [15:0] best_rem;
        r = '0;
        n = (proc_count > 16) ? 16 : proc_count;
        found = 0;
        best = 0;
        best_rem = 0;
        case (op)
            OP_LOAD:
            begin
                r.chosen_slot = sl;
                arrival_mem[sl] = arr;
                remain_mem[sl] = bur;
                wait_mem[sl] = 0;
                finish_mem[sl] = 0;
                done_bits[sl] = 1'b0;
            end
            OP_REPORT:
            begin
                r.chosen_slot = sl;
                r.wait_total = wait_mem[sl];
                if (done_bits[sl])
                begin
                    r.turnaround = finish_mem[sl] - arrival_mem[sl];
                    r.has_finished = 1'b1;
                end
            end
            OP_TICK:
            begin
                r.tick_time = now;
                if (now >= run_len)
                    r.past_end = 1'b1;
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (arrival_mem[i] == now)
                            r.arrived_mask[i] = 1'b1;
                        if (remain_mem[i] > 0 && arrival_mem[i] <= now &&
                            (!found || remain_mem[i] < best_rem))
                        begin
                            found = 1;
                            best = i;
                            best_rem = remain_mem[i];
                        end
                    end
                    if (!found)
                        r.idle = 1'b1;
                    else
                    begin
                        r.new_selection = !prev_pick_ok || prev_pick != best[3:0];
                        prev_pick = best[3:0];
                        prev_pick_ok = 1'b1;
                        r.chosen_slot = best[3:0];
                        r.burst_left = best_rem;
                        remain_mem[best] = best_rem - 1;
                        if (remain_mem[best] == 0)
                        begin
                            r.finished = 1'b1;
                            finish_mem[best] = now + 1;
                            done_bits[best] = 1'b1;
                        end
                        for (int i = 0; i < n; i++)
                            if (i != best && remain_mem[i] > 0 && arrival_mem[i] <= now &&
                                wait_mem[i] != 16'hFFFF)
                                wait_mem[i]++;
                    end
                    now = now + 1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    initial failures = 0;

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                arrival_mem[i] = 0;
                remain_mem[i] = 0;
                wait_mem[i] = 0;
                finish_mem[i] = 0;
            end
            done_bits = 0;
            now = 0;
            prev_pick = 0;
            prev_pick_ok = 0;
            proc_count = 5'd1;
            run_len = 0;
            result_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (result_q.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = result_q.pop_front();
                    check_field("tick_time", tick_time, want.tick_time);
                    check_field("arrived_mask", arrived_mask, want.arrived_mask);
                    check_field("idle", idle, want.idle);
                    check_field("new_selection", new_selection, want.new_selection);
                    check_field("chosen_slot", chosen_slot, want.chosen_slot);
                    check_field("burst_left", burst_left, want.burst_left);
                    check_field("finished", finished, want.finished);
                    check_field("past_end", past_end, want.past_end);
                    check_field("wait_total", wait_total, want.wait_total);
                    check_field("turnaround", turnaround, want.turnaround);
                    check_field("has_finished", has_finished, want.has_finished);
                end
            end
            if (start && !busy)
                result_q.push_back(schedule_step(opcode, slot, arrival_time, burst_time));
            if (cfg_we)
            begin
                if (cfg_index == REG_PROCESS_COUNT)
                    proc_count = cfg_data[4:0];
                else
                    run_len = cfg_data;
            end
        end
    end

endmodule

>>> dv/tb.sv
// testbench top for the srtf scheduler: stimulus, pacing and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srtf_pkg::*;

    // opcode the block must answer with zeros
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  opcode = OP_LOAD;
    logic [3:0]  slot = '0;
    logic [15:0] arrival_time = '0;
    logic [15:0] burst_time = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_PROCESS_COUNT;
    logic [15:0] cfg_data = '0;

    logic        busy;
    logic        done;
    logic [15:0] tick_time;
    logic [15:0] arrived_mask;
    logic        idle;
    logic        new_selection;
    logic [3:0]  chosen_slot;
    logic [15:0] burst_left;
    logic        finished;
    logic        past_end;
    logic [15:0] wait_total;
    logic [15:0] turnaround;
    logic        has_finished;
    int          failures;
    int          pending;

    // stimulus-side view of the schedule, used only to aim arrivals near now
    int          sched_now;
    int          sched_end;
    int          gap_pct;
    int          items_sent;

    always #2 clk = ~clk;

    srtf_process_scheduler dut (.*);

    srtf_checker u_checker (.*);

    // hard stop in case the block hangs
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    // present one item and hold it until the block takes it
    task automatic send_item(input logic [1:0] op, input logic [3:0] sl,
                             input logic [15:0] arr, input logic [15:0] bur);
        start <= 1'b1;
        opcode <= op;
        slot <= sl;
        arrival_time <= arr;
        burst_time <= bur;
        // busy only moves at rising edges, so sample it mid-cycle
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        items_sent++;
        // time only moves while the run has ticks left
        if (op == OP_TICK && sched_now < sched_end)
            sched_now++;
        // random sender gaps, some phases none at all
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // drop start and wait for every expected item to come back
    task automatic drain;
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0 || busy);
        @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_RUN_LENGTH)
            sched_end = val;
    endtask

    // load aimed at the near future so slots actually compete
    task automatic load_near(input logic [3:0] sl);
        if ($urandom_range(15) == 0)
            send_item(OP_LOAD, sl, 16'($urandom), 16'($urandom));
        else
            send_item(OP_LOAD, sl, 16'(sched_now + $urandom_range(0, 6)),
                      16'($urandom_range(0, 6)));
    endtask

    initial
    begin
        int phase;
        int pick;
        sched_now = 0;
        sched_end = 0;
        gap_pct = 0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill every slot so no unwritten arrival is ever read
        write_reg(REG_PROCESS_COUNT, 16'd16);
        for (int i = 0; i < 14; i++)
            send_item(OP_LOAD, 4'(i), 16'(i % 3), 16'(1 + (i % 4)));
        // zero burst never runs, far arrival never arrives
        send_item(OP_LOAD, 4'd14, 16'd1, 16'd0);
        send_item(OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF);
        // tick with a run length of zero is past the end
        send_item(OP_TICK, 4'd0, 16'd0, 16'd0);
        send_item(OP_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF);
        send_item(OP_REPORT, 4'd0, 16'd0, 16'd0);
        write_reg(REG_RUN_LENGTH, 16'd40);
        repeat (4) send_item(OP_TICK, 4'd0, 16'd0, 16'd0);
        send_item(OP_REPORT, 4'd3, 16'd0, 16'd0);
        send_item(OP_REPORT, 4'd15, 16'd0, 16'd0);

        // random phases with changing settings and sender pacing
        phase = 0;
        while (items_sent < 1650)
        begin
            case (phase % 4)
                0: gap_pct = 0;
                1: gap_pct = 50;
                2: gap_pct = 0;
                default: gap_pct = 18;
            endcase
            pick = $urandom_range(7);
            case (pick)
                0: write_reg(REG_PROCESS_COUNT, 16'd0);
                1: write_reg(REG_PROCESS_COUNT, 16'd1);
                2: write_reg(REG_PROCESS_COUNT, 16'd31);
                3: write_reg(REG_PROCESS_COUNT, 16'd16);
                default: write_reg(REG_PROCESS_COUNT, 16'($urandom_range(1, 20)));
            endcase
            pick = $urandom_range(9);
            if (pick == 0)
                write_reg(REG_RUN_LENGTH, 16'(sched_now));
            else if (pick == 1)
                write_reg(REG_RUN_LENGTH, 16'hFFFF);
            else
                write_reg(REG_RUN_LENGTH, 16'(sched_now + $urandom_range(10, 50)));
            repeat ($urandom_range(2, 8)) load_near(4'($urandom_range(15)));
            repeat ($urandom_range(20, 40))
            begin
                pick = $urandom_range(99);
                if (pick < 68)
                    send_item(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
                else if (pick < 84)
                    send_item(OP_REPORT, 4'($urandom), 16'($urandom), 16'($urandom));
                else if (pick < 96)
                    load_near(4'($urandom_range(15)));
                else
                    send_item(OP_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom));
            end
            phase++;
        end

        // wind down and let any stray result show up
        drain();
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
